@@ hw/rtl/fupa_pkg.sv @@
package fupa_pkg;

	// Fixed field widths
	localparam int ADDR_W       = 32;
	localparam int POOL_FIELD_W = 11;
	localparam int STATUS_W     = 2;
	localparam int PDATA_W      = 32;
	localparam int PADDR_W      = 3;

	// Request codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Register index (paddr[2])
	localparam logic REG_BASE = 1'b0;
	localparam logic REG_POOL = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic sweep_clr;  // restart the stack refill pointer
		logic sweep;      // write identity entry, advance pointer
		logic capture;    // latch a new item
		logic eval;       // read stack head and top, load divider
		logic div_step;   // quotient by reciprocal multiply
		logic commit;     // write back stack and count, load result
		logic fail;       // load a failure result
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic refill;     // unit count written this cycle
		logic sweep_last; // pointer at last stack entry
		logic op_free;    // latched item is a free
		logic empty;      // no free units
		logic outside;    // free address not inside the pool
		logic full;       // free stack already full
		logic unit_pow2;  // unit index is a plain bit slice
		logic div_last;   // division finishes this cycle
	} sts_t;

endpackage

@@ hw/rtl/fupa_ctrl.sv @@
module fupa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  fupa_pkg::sts_t  sts,
	output fupa_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_INIT   = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_EVAL   = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	// New items are taken when idle or while the previous one commits
	assign busy   = !((state_q == S_IDLE) || (state_q == S_COMMIT));
	assign accept = start && !busy;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_INIT: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (!sts.op_free) begin
					if (sts.empty) begin
						cmd.fail = 1'b1;
						state_d  = S_IDLE;
					end else begin
						state_d = S_COMMIT;
					end
				end else if (sts.outside || sts.full) begin
					cmd.fail = 1'b1;
					state_d  = S_IDLE;
				end else if (sts.unit_pow2) begin
					state_d = S_COMMIT;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				if (accept) begin
					cmd.capture = 1'b1;
					state_d     = S_EVAL;
				end else begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
		// unit count write restarts the refill pass
		if (sts.refill) begin
			cmd           = '0;
			cmd.sweep_clr = 1'b1;
			state_d       = S_INIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/fupa_dp.sv @@
module fupa_dp #(
	parameter int MAX_UNITS  = 1024,
	parameter int UNIT_BYTES = 64,
	parameter int CNT_W      = 11
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// item
	input  logic                               operation,
	input  logic [fupa_pkg::ADDR_W-1:0]        address,
	// result
	output logic                               done,
	output logic [fupa_pkg::ADDR_W-1:0]        unit_address,
	output logic [fupa_pkg::STATUS_W-1:0]      status,
	output logic [CNT_W-1:0]                   free_units,
	// register port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [fupa_pkg::PADDR_W-1:0]       paddr,
	input  logic [fupa_pkg::PDATA_W-1:0]       pwdata,
	output logic [fupa_pkg::PDATA_W-1:0]       prdata,
	// control
	input  fupa_pkg::cmd_t                     cmd,
	output fupa_pkg::sts_t                     sts
);

	localparam int IDX_W     = $clog2(MAX_UNITS);
	localparam int SPAN_W    = $clog2(MAX_UNITS * UNIT_BYTES + 1);
	localparam int UNIT_LOG  = $clog2(UNIT_BYTES);
	localparam bit UNIT_POW2 = ((UNIT_BYTES & (UNIT_BYTES - 1)) == 0);

	// Registers
	logic [fupa_pkg::ADDR_W-1:0]   base_q;
	logic [CNT_W-1:0]              pool_q;
	logic [SPAN_W-1:0]             span_q;
	logic [CNT_W-1:0]              count_q;
	logic [IDX_W-1:0]              ptr_q;
	logic                          op_q;
	logic [fupa_pkg::ADDR_W-1:0]   addr_q;
	logic [IDX_W-1:0]              head_q;
	logic [IDX_W-1:0]              top_q;
	logic                          done_q;
	logic [fupa_pkg::ADDR_W-1:0]   uaddr_q;
	logic [fupa_pkg::STATUS_W-1:0] status_q;
	logic [CNT_W-1:0]              free_q;

	logic [IDX_W-1:0]              stack_mem [MAX_UNITS];

	logic                          cfg_wr;
	logic [fupa_pkg::POOL_FIELD_W-1:0] pool_field;
	logic [CNT_W-1:0]              pool_new;
	logic [fupa_pkg::ADDR_W-1:0]   offset;
	logic [CNT_W-1:0]              cnt_dec;
	logic [IDX_W-1:0]              top_idx;
	logic [IDX_W-1:0]              push_idx;
	logic                          div_last;
	logic                          mem_we;
	logic [IDX_W-1:0]              mem_wa;
	logic [IDX_W-1:0]              mem_wd;

	// Register writes
	assign cfg_wr     = psel && penable && pwrite;
	assign pool_field = pwdata[fupa_pkg::POOL_FIELD_W-1:0];
	assign pool_new   = (32'(pool_field) > 32'(MAX_UNITS)) ? CNT_W'(MAX_UNITS)
	                                                       : CNT_W'(pool_field);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			pool_q <= CNT_W'(MAX_UNITS);
			span_q <= SPAN_W'(MAX_UNITS) * SPAN_W'(UNIT_BYTES);
		end else if (cfg_wr) begin
			if (paddr[2] == fupa_pkg::REG_BASE) begin
				base_q <= pwdata;
			end else begin
				pool_q <= pool_new;
				span_q <= SPAN_W'(pool_new) * SPAN_W'(UNIT_BYTES);
			end
		end
	end

	assign prdata = (paddr[2] == fupa_pkg::REG_POOL) ? fupa_pkg::PDATA_W'(pool_q) : base_q;

	// Request evaluation
	assign offset  = addr_q - base_q;
	assign cnt_dec = count_q - CNT_W'(1);
	assign top_idx = cnt_dec[IDX_W-1:0];

	assign sts.refill     = cfg_wr && (paddr[2] == fupa_pkg::REG_POOL);
	assign sts.sweep_last = (ptr_q == IDX_W'(MAX_UNITS - 1));
	assign sts.op_free    = (op_q == fupa_pkg::OP_FREE);
	assign sts.empty      = (count_q == '0);
	assign sts.outside    = (offset >= fupa_pkg::ADDR_W'(span_q));
	assign sts.full       = (count_q >= pool_q);
	assign sts.unit_pow2  = UNIT_POW2;
	assign sts.div_last   = div_last;

	// Offset to unit index
	generate
		if (UNIT_POW2) begin : g_shift
			assign push_idx = offset[UNIT_LOG+IDX_W-1:UNIT_LOG];
			assign div_last = 1'b1;
		end else begin : g_div
			localparam int RCP_SH = SPAN_W + UNIT_LOG;
			localparam int RCP_W  = SPAN_W + 2;
			localparam int PROD_W = SPAN_W + RCP_W;
			localparam longint unsigned RCP =
				((64'd1 << RCP_SH) + 64'(UNIT_BYTES) - 64'd1) / 64'(UNIT_BYTES);
			logic [SPAN_W-1:0] rem_q;
			logic [IDX_W-1:0]  quot_q;
			logic [PROD_W-1:0] prod;

			// multiply by the rounded-up reciprocal, exact for every in-pool offset
			assign prod     = PROD_W'(rem_q) * PROD_W'(RCP);
			assign div_last = 1'b1;
			assign push_idx = quot_q;

			always_ff @(posedge clk) begin
				if (cmd.eval) begin
					rem_q <= offset[SPAN_W-1:0];
				end else if (cmd.div_step) begin
					quot_q <= prod[RCP_SH+IDX_W-1:RCP_SH];
				end
			end
		end
	endgenerate

	// Free count and refill pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(MAX_UNITS);
			ptr_q   <= '0;
		end else begin
			if (sts.refill) begin
				count_q <= pool_new;
			end else if (cmd.commit) begin
				count_q <= sts.op_free ? (count_q + CNT_W'(1)) : cnt_dec;
			end
			if (cmd.sweep_clr) begin
				ptr_q <= '0;
			end else if (cmd.sweep) begin
				ptr_q <= ptr_q + IDX_W'(1);
			end
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= operation;
			addr_q <= address;
		end
	end

	// Stack memory: one write port, two registered read ports
	always_comb begin
		mem_we = 1'b0;
		mem_wa = ptr_q;
		mem_wd = ptr_q;
		if (cmd.sweep) begin
			mem_we = 1'b1;
		end else if (cmd.commit) begin
			mem_we = 1'b1;
			if (sts.op_free) begin
				mem_wa = count_q[IDX_W-1:0];
				mem_wd = push_idx;
			end else begin
				mem_wa = '0;
				mem_wd = top_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_wa] <= mem_wd;
		end
		if (cmd.eval) begin
			head_q <= stack_mem[0];
			top_q  <= stack_mem[top_idx];
		end
	end

	// Result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit || cmd.fail;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= fupa_pkg::ST_OK;
			if (sts.op_free) begin
				uaddr_q <= '0;
				free_q  <= count_q + CNT_W'(1);
			end else begin
				uaddr_q <= base_q + (fupa_pkg::ADDR_W'(head_q) * fupa_pkg::ADDR_W'(UNIT_BYTES));
				free_q  <= cnt_dec;
			end
		end else if (cmd.fail) begin
			uaddr_q <= '0;
			free_q  <= count_q;
			if (!sts.op_free) begin
				status_q <= fupa_pkg::ST_EMPTY;
			end else if (sts.outside) begin
				status_q <= fupa_pkg::ST_OUTSIDE;
			end else begin
				status_q <= fupa_pkg::ST_FULL;
			end
		end
	end

	assign done         = done_q;
	assign unit_address = uaddr_q;
	assign status       = status_q;
	assign free_units   = free_q;

endmodule

@@ hw/rtl/fixed_unit_pool_allocator_unit.sv @@
// Fixed-size unit pool allocator with a free stack of unit indices.
// Request channel: drive operation (0 allocate, 1 free) and address with
// start; the item is taken at a rising edge where start is high and busy low.
// Result channel: done is high for exactly one cycle with unit_address,
// status and free_units; the receiver must take it then, it cannot stall.
// A failed request is decided in the evaluate step and done follows from
// the result register; a successful one passes evaluate then commit, and
// a successful free also passes a divide step (reciprocal multiply) when
// UNIT_BYTES is not a power of two.
// The item rate is set by the read then write-back of the stack memory
// (head and top read, then one write).
// A new item can be accepted in the cycle the previous one writes back.
// Registers (APB, pready tied high): 0x0 base_address, 0x4 pool_units.
// Reset and every pool_units write start a refill pass that writes the
// identity order into all MAX_UNITS stack entries, with busy held high;
// register writes are still taken during the pass.
module fixed_unit_pool_allocator_unit #(
	parameter int MAX_UNITS  = 1024,
	parameter int UNIT_BYTES = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 operation,
	input  logic [fupa_pkg::ADDR_W-1:0]          address,
	output logic                                 done,
	output logic [fupa_pkg::ADDR_W-1:0]          unit_address,
	output logic [fupa_pkg::STATUS_W-1:0]        status,
	output logic [$clog2(MAX_UNITS+1)-1:0]       free_units,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [fupa_pkg::PADDR_W-1:0]         paddr,
	input  logic [fupa_pkg::PDATA_W-1:0]         pwdata,
	output logic [fupa_pkg::PDATA_W-1:0]         prdata,
	output logic                                 pready
);

	localparam int CNT_W = $clog2(MAX_UNITS + 1);

	fupa_pkg::cmd_t cmd;
	fupa_pkg::sts_t sts;

	assign pready = 1'b1;

	fupa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	fupa_dp #(
		.MAX_UNITS  (MAX_UNITS),
		.UNIT_BYTES (UNIT_BYTES),
		.CNT_W      (CNT_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.operation    (operation),
		.address      (address),
		.done         (done),
		.unit_address (unit_address),
		.status       (status),
		.free_units   (free_units),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.cmd          (cmd),
		.sts          (sts)
	);

	// Failed requests return no address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != fupa_pkg::ST_OK)) |-> (unit_address == '0))
		else $error("failed request returned an address");

	// Empty pool is reported only with no free units
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == fupa_pkg::ST_EMPTY)) |-> (free_units == '0))
		else $error("pool empty reported with free units left");

	// Full stack is reported only with free units present
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == fupa_pkg::ST_FULL)) |-> (free_units != '0))
		else $error("stack full reported with no free units");

endmodule
